// ===== hdl/mtb_pkg.sv =====
// shared constants, types and opcodes for the timer bank
package mtb_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int TIME_BITS   = 32;
   localparam int MAX_RESULTS = 16;
   localparam int OPCODE_W    = 3;
   localparam int INDEX_W     = 4;
   localparam int TIU_W       = 5;
   localparam int OUT_TIME_W  = 32;

   localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
   localparam int CMP_A   = (TIU_W > CNT_W) ? TIU_W : CNT_W;
   localparam int CMP_W   = (CMP_A > INDEX_W) ? CMP_A : INDEX_W;
   localparam int FIRED_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK      = 3'd0,
      OP_START_ONE = 3'd1,
      OP_START_PER = 3'd2,
      OP_STOP      = 3'd3,
      OP_SCAN      = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] period;
      logic                 armed;
   } entry_type;

   typedef struct packed {
      op_type op;
      logic   hit;
      logic   active;
      logic   room;
   } head_ctl_type;

   typedef struct packed {
      logic fire;
      logic periodic;
   } head_res_type;

endpackage

// ===== hdl/multi_timer_bank.sv =====
// top level: bank of software timers held in a rotating ring of slots
// a tick is taken in the idle state; start, stop and scan rotate the whole ring,
// slot by slot, before the bank takes a new request
// a scan then hands out its final expiry from the flush state; a stalled
// response channel holds the ring while a further expiry waits
// reset clears the tick counter, the armed bits and the timer count;
// deadlines and periods are not cleared
module multi_timer_bank import mtb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [INDEX_W-1:0]    req_timer_index,
   input  logic [31:0]           req_duration,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_W-1:0]    rsp_expired_index,
   output logic [OUT_TIME_W-1:0] rsp_fire_time,
   output logic                  rsp_was_periodic,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TIU_W-1:0]      csr_wdata
);

   state_type            state_ff, state_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [TIU_W-1:0]     tiu_ff;
   op_type               op_ff, op_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [TIME_BITS-1:0] dur_ff, dur_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [FIRED_W-1:0]   fired_ff, fired_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [INDEX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic                 pend_per_ff, pend_per_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_idx_ff;
   logic [OUT_TIME_W-1:0] rsp_time_ff;
   logic                 rsp_per_ff;
   logic                 rsp_last_ff;

   logic                 shift;
   logic                 out_free;
   logic                 out_load;
   logic                 out_last;
   logic [CMP_W-1:0]     active_cnt;
   head_ctl_type         ctl;
   head_res_type         res;
   entry_type            head_out;
   entry_type            cell_q [NUM_TIMERS];

   // ring: slot k takes from slot k+1, the last slot takes the updated head
   for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_ring
      if (k == NUM_TIMERS - 1) begin : g_tail
         mtb_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .nbr_entry (head_out),
            .entry     (cell_q[k])
         );
      end else begin : g_body
         mtb_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .nbr_entry (cell_q[k+1]),
            .entry     (cell_q[k])
         );
      end
   end

   always_comb begin
      active_cnt = (CMP_W'(tiu_ff) > CMP_W'(NUM_TIMERS)) ? CMP_W'(NUM_TIMERS)
                                                          : CMP_W'(tiu_ff);
      ctl.op     = op_ff;
      ctl.hit    = (CMP_W'(pos_ff) == CMP_W'(idx_ff));
      ctl.active = (CMP_W'(pos_ff) < active_cnt);
      ctl.room   = (fired_ff < FIRED_W'(MAX_RESULTS));
   end

   mtb_head u_head (
      .ctl       (ctl),
      .now       (tick_ff),
      .duration  (dur_ff),
      .entry_in  (cell_q[0]),
      .entry_out (head_out),
      .res       (res)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      dur_in        = dur_ff;
      pos_in        = pos_ff;
      fired_in      = fired_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_per_in   = pend_per_ff;
      shift         = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      req_ready     = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_opcode))
                  OP_TICK: begin
                     tick_in = tick_ff + 1'b1;
                  end
                  OP_START_ONE, OP_START_PER, OP_STOP, OP_SCAN: begin
                     op_in    = op_type'(req_opcode);
                     idx_in   = req_timer_index;
                     dur_in   = TIME_BITS'(req_duration);
                     pos_in   = '0;
                     fired_in = '0;
                     state_in = ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            // hold the ring while a second expiry has nowhere to go
            if (!(res.fire && pend_valid_ff && !out_free)) begin
               shift  = 1'b1;
               pos_in = pos_ff + 1'b1;
               if (res.fire) begin
                  fired_in      = fired_ff + 1'b1;
                  out_load      = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_idx_in   = INDEX_W'(pos_ff);
                  pend_per_in   = res.periodic;
               end
               if (pos_ff == IDX_W'(NUM_TIMERS - 1)) begin
                  pos_in   = '0;
                  state_in = (op_ff == OP_SCAN) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         tiu_ff        <= '0;
         pos_ff        <= '0;
         fired_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         pos_ff        <= pos_in;
         fired_ff      <= fired_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tiu_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      dur_ff      <= dur_in;
      pend_idx_ff <= pend_idx_in;
      pend_per_ff <= pend_per_in;
      if (out_load) begin
         rsp_idx_ff  <= pend_idx_ff;
         rsp_per_ff  <= pend_per_ff;
         rsp_last_ff <= out_last;
         rsp_time_ff <= OUT_TIME_W'(tick_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expired_index = rsp_idx_ff;
   assign rsp_fire_time     = rsp_time_ff;
   assign rsp_was_periodic  = rsp_per_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== hdl/mtb_cell.sv =====
// one timer slot of the rotating ring
module mtb_cell import mtb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type nbr_entry,
   output entry_type entry
);

   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic                 armed_ff, armed_in;

   always_comb begin
      deadline_in = shift ? nbr_entry.deadline : deadline_ff;
      period_in   = shift ? nbr_entry.period : period_ff;
      armed_in    = shift ? nbr_entry.armed : armed_ff;
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      period_ff   <= period_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   assign entry.deadline = deadline_ff;
   assign entry.period   = period_ff;
   assign entry.armed    = armed_ff;

endmodule

// ===== hdl/mtb_head.sv =====
// update of the timer slot passing the head of the ring
module mtb_head import mtb_pkg::*; (
   input  head_ctl_type         ctl,
   input  logic [TIME_BITS-1:0] now,
   input  logic [TIME_BITS-1:0] duration,
   input  entry_type            entry_in,
   output entry_type            entry_out,
   output head_res_type         res
);

   logic [TIME_BITS-1:0] add_b;
   logic [TIME_BITS-1:0] sum;
   logic [TIME_BITS-1:0] diff;
   logic                 due;

   always_comb begin
      // one adder serves both start and reschedule
      add_b = (ctl.op == OP_SCAN) ? entry_in.period : duration;
      sum   = now + add_b;
      diff  = now - entry_in.deadline;
      due   = entry_in.armed && !diff[TIME_BITS-1];

      entry_out = entry_in;
      res       = '0;

      case (ctl.op)
         OP_START_ONE, OP_START_PER: begin
            if (ctl.hit && ctl.active) begin
               entry_out.deadline = sum;
               entry_out.period   = (ctl.op == OP_START_PER) ? duration : '0;
               entry_out.armed    = 1'b1;
            end
         end
         OP_STOP: begin
            if (ctl.hit && ctl.active) begin
               entry_out.armed = 1'b0;
            end
         end
         OP_SCAN: begin
            if (ctl.active && ctl.room && due) begin
               res.fire     = 1'b1;
               res.periodic = (entry_in.period != '0);
               if (entry_in.period != '0) begin
                  entry_out.deadline = sum;
               end else begin
                  entry_out.armed = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the timer bank: directed table, then random request phases
module tb_top;
   import mtb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OPCODE_W-1:0] OP_RSVD_A = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_RSVD_B = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_RSVD_C = 3'd7;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PRINT_CAP     = 200;

   typedef struct packed {
      logic [INDEX_W-1:0]    index;
      logic [OUT_TIME_W-1:0] fire_time;
      logic                  periodic;
      logic                  last;
   } expiry_type;

   typedef struct packed {
      bit                  is_cfg;
      logic [TIU_W-1:0]    cfg_value;
      logic [OPCODE_W-1:0] op;
      logic [INDEX_W-1:0]  idx;
      logic [31:0]         dur;
      bit                  typed;
      expiry_type          want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [INDEX_W-1:0]    req_timer_index = '0;
   logic [31:0]           req_duration = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [INDEX_W-1:0]    rsp_expired_index;
   logic [OUT_TIME_W-1:0] rsp_fire_time;
   logic                  rsp_was_periodic;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TIU_W-1:0]      csr_wdata = '0;

   multi_timer_bank dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_timer_index   (req_timer_index),
      .req_duration      (req_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_expired_index (rsp_expired_index),
      .rsp_fire_time     (rsp_fire_time),
      .rsp_was_periodic  (rsp_was_periodic),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // timer bank shadow state
   logic [TIME_BITS-1:0] now_ticks = '0;
   logic [TIME_BITS-1:0] due_at [NUM_TIMERS];
   logic [TIME_BITS-1:0] reload [NUM_TIMERS];
   logic                 armed  [NUM_TIMERS];
   logic [TIU_W-1:0]     timer_count_model = '0;

   expiry_type   scan_hits[$];
   expiry_type   pending_expiries[$];
   stim_row_type directed_rows[$];

   int mismatch_count = 0;
   bit idling_on = 1'b1;
   bit hold_pending = 1'b0;

   initial begin
      for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
   end

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, name, got, want);
         mismatch_count++;
      end
   endtask

   function automatic int live_timers();
      return (timer_count_model > NUM_TIMERS) ? NUM_TIMERS : int'(timer_count_model);
   endfunction

   // advances the shadow bank by one request, expiries land in scan_hits
   task automatic predict_request(input logic [OPCODE_W-1:0] op,
                                  input logic [INDEX_W-1:0] idx,
                                  input logic [31:0] dur);
      int live;
      int slot;
      logic [TIME_BITS-1:0] lag;
      expiry_type hit;
      scan_hits.delete();
      live = live_timers();
      case (op)
         OP_TICK: now_ticks = now_ticks + 1'b1;
         OP_START_ONE, OP_START_PER: begin
            if (idx < live) begin
               due_at[idx] = now_ticks + dur;
               reload[idx] = (op == OP_START_PER) ? dur : '0;
               armed[idx]  = 1'b1;
            end
         end
         OP_STOP: begin
            if (idx < live) armed[idx] = 1'b0;
         end
         OP_SCAN: begin
            for (slot = 0; slot < live && scan_hits.size() < MAX_RESULTS; slot++) begin
               if (armed[slot]) begin
                  lag = now_ticks - due_at[slot];
                  // due when the wrapped difference is not negative
                  if (!lag[TIME_BITS-1]) begin
                     hit.index     = slot[INDEX_W-1:0];
                     hit.fire_time = now_ticks[OUT_TIME_W-1:0];
                     hit.periodic  = (reload[slot] != '0);
                     hit.last      = 1'b0;
                     if (hit.periodic) due_at[slot] = now_ticks + reload[slot];
                     else armed[slot] = 1'b0;
                     scan_hits.push_back(hit);
                  end
               end
            end
         end
         default: ;
      endcase
      if (scan_hits.size() > 0) begin
         hit = scan_hits.pop_back();
         hit.last = 1'b1;
         scan_hits.push_back(hit);
      end
   endtask

   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                               input logic [31:0] dur, input bit typed,
                               input expiry_type want);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_opcode      = op;
      req_timer_index = idx;
      req_duration    = dur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(op, idx, dur);
      if (typed) pending_expiries.push_back(want);
      else foreach (scan_hits[i]) pending_expiries.push_back(scan_hits[i]);
   endtask

   // block idle: no request offered, all expiries out, ring rotation done
   task automatic settle_bank();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_expiries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timer_count(input logic [TIU_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      timer_count_model = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic add_cfg_row(input logic [TIU_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg_value = value;
      directed_rows.push_back(row);
   endtask

   task automatic add_req_row(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic [31:0] dur);
      stim_row_type row;
      row = '0;
      row.op = op;
      row.idx = idx;
      row.dur = dur;
      directed_rows.push_back(row);
   endtask

   // scan with one known expiry, which is then also the last
   task automatic add_typed_scan(input logic [INDEX_W-1:0] want_idx,
                                 input logic [OUT_TIME_W-1:0] want_time, input logic want_per);
      stim_row_type row;
      row = '0;
      row.op = OP_SCAN;
      row.typed = 1'b1;
      row.want.index = want_idx;
      row.want.fire_time = want_time;
      row.want.periodic = want_per;
      row.want.last = 1'b1;
      directed_rows.push_back(row);
   endtask

   task automatic run_random_phase(input logic [TIU_W-1:0] count_value, input int target,
                                   input bit with_hold);
      int counted;
      int live;
      int pick;
      logic [OPCODE_W-1:0] op;
      logic [INDEX_W-1:0] idx;
      logic [31:0] dur;
      settle_bank();
      write_timer_count(count_value);
      live = live_timers();
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) op = OP_TICK;
         else if (pick < 50) op = OP_START_ONE;
         else if (pick < 65) op = OP_START_PER;
         else if (pick < 73) op = OP_STOP;
         else if (pick < 95) op = OP_SCAN;
         else begin
            case ($urandom_range(0, 2))
               0: op = OP_RSVD_A;
               1: op = OP_RSVD_B;
               default: op = OP_RSVD_C;
            endcase
         end
         if (live > 0 && $urandom_range(0, 4) != 0)
            idx = INDEX_W'($urandom_range(0, live - 1));
         else
            idx = INDEX_W'($urandom_range(0, NUM_TIMERS - 1));
         pick = $urandom_range(0, 9);
         if (pick < 7) dur = $urandom_range(0, 12);
         else if (pick < 9) dur = $urandom;
         else begin
            case ($urandom_range(0, 2))
               0: dur = 32'hFFFF_FFFF;
               1: dur = 32'h8000_0000;
               default: dur = 32'h7FFF_FFFF;
            endcase
         end
         // long response stall once twenty requests have been counted
         if (with_hold && counted == 20) begin
            hold_pending = 1'b1;
            with_hold = 1'b0;
         end
         send_request(op, idx, dur, 1'b0, '0);
         if (op == OP_TICK || op == OP_SCAN ||
             ((op == OP_START_ONE || op == OP_START_PER || op == OP_STOP) && idx < live))
            counted++;
      end
   endtask

   initial begin : rsp_drive
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) stall_left--;
         else if (hold_pending) begin
            stall_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         rsp_ready = (stall_left == 0);
      end
   end

   always @(posedge clock) begin : rsp_check
      expiry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_expiries.size() == 0) begin
            compare_field("unexpected expiry index", 32'(rsp_expired_index), 'x);
         end else begin
            want = pending_expiries.pop_front();
            compare_field("expired_index", 32'(rsp_expired_index), 32'(want.index));
            compare_field("fire_time", rsp_fire_time, want.fire_time);
            compare_field("was_periodic", 32'(rsp_was_periodic), 32'(want.periodic));
            compare_field("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_cfg_row(5'd16);
      add_req_row(OP_SCAN, 4'd0, 32'd0);              // nothing armed yet
      add_req_row(OP_START_ONE, 4'd0, 32'd0);         // zero delay
      add_typed_scan(4'd0, 32'd0, 1'b0);
      add_req_row(OP_START_PER, 4'd15, 32'd0);        // zero period behaves as one-shot
      add_typed_scan(4'd15, 32'd0, 1'b0);
      add_req_row(OP_START_PER, 4'd3, 32'd2);
      add_req_row(OP_TICK, 4'd0, 32'd0);
      add_req_row(OP_TICK, 4'd0, 32'd0);
      add_typed_scan(4'd3, 32'd2, 1'b1);
      add_req_row(OP_START_ONE, 4'd5, 32'hFFFF_FFFF); // deadline wraps behind now
      add_req_row(OP_START_ONE, 4'd7, 32'h8000_0000); // half range ahead, not due
      add_req_row(OP_STOP, 4'd3, 32'd0);
      add_typed_scan(4'd5, 32'd2, 1'b0);
      add_req_row(OP_RSVD_A, 4'd0, 32'd0);
      add_req_row(OP_RSVD_C, 4'd15, 32'hFFFF_FFFF);
      add_req_row(OP_START_PER, 4'd0, 32'd1);
      add_req_row(OP_START_ONE, 4'd1, 32'd0);
      add_req_row(OP_START_ONE, 4'd15, 32'd0);
      add_req_row(OP_SCAN, 4'd0, 32'd0);              // several expiries in one scan
      add_cfg_row(5'd4);
      add_req_row(OP_START_ONE, 4'd9, 32'd0);         // index beyond count, ignored
      add_req_row(OP_START_ONE, 4'd4, 32'd0);         // index equal to count, ignored
      add_req_row(OP_STOP, 4'd7, 32'd0);              // ignored, timer 7 stays armed
      add_req_row(OP_TICK, 4'd0, 32'd0);
      add_typed_scan(4'd0, 32'd3, 1'b1);
      add_cfg_row(5'd0);
      add_req_row(OP_SCAN, 4'd0, 32'd0);
      add_req_row(OP_RSVD_B, 4'd0, 32'd0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            settle_bank();
            write_timer_count(row.cfg_value);
         end else begin
            send_request(row.op, row.idx, row.dur, row.typed, row.want);
         end
      end

      run_random_phase(5'd31, 60, 1'b1);
      run_random_phase(5'd0, 10, 1'b0);
      run_random_phase(5'd9, 50, 1'b0);
      run_random_phase(5'd1, 30, 1'b0);
      run_random_phase(TIU_W'($urandom_range(2, 15)), 50, 1'b0);
      settle_bank();
      idling_on = 1'b0;
      run_random_phase(5'd16, 60, 1'b0);

      settle_bank();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
